// ===== rtl/text_terminal_cursor_scroll_top_macros.svh =====
// Assertion macros for the text terminal block.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef TEXT_TERMINAL_CURSOR_SCROLL_TOP_MACROS_SVH
`define TEXT_TERMINAL_CURSOR_SCROLL_TOP_MACROS_SVH

// same-cycle implication
`define TTCS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TTCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ttcs_pkg.sv =====
// Shared types and constants for the text terminal block.
// No dependencies.
package ttcs_pkg;

  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;

  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] COLOR_RESET  = 8'h07;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef enum logic [1:0] {
    AU_HOLD,
    AU_LOAD,
    AU_INC,
    AU_CLR
  } au_op_e;

  function automatic logic [15:0] make_cell(input logic [7:0] ch, input logic [7:0] color);
    return {color, ch};
  endfunction

endpackage

// ===== rtl/ttcs_cell_ram.sv =====
// Screen cell store: one write port, one registered read port.
// Depends on nothing.
module ttcs_cell_ram #(
  parameter int unsigned DEPTH = 2000,
  parameter int unsigned AW    = 11
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [15:0]   wdata_i,
  output logic [15:0]   rdata_o
);

  logic [15:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== rtl/ttcs_addr_unit.sv =====
// Shared cell address unit: row offset wrap, row*COLUMNS+col, step, zero.
// Depends on ttcs_pkg.
module ttcs_addr_unit #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25,
  localparam int unsigned AW = $clog2(ROWS * COLUMNS),
  localparam int unsigned RW = $clog2(ROWS),
  localparam int unsigned CW = $clog2(COLUMNS)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ttcs_pkg::au_op_e op_i,
  input  logic [RW-1:0]  row_i,
  input  logic [CW-1:0]  col_i,
  input  logic [RW-1:0]  top_i,
  output logic [AW-1:0]  addr_o
);
  import ttcs_pkg::*;

  localparam logic [AW-1:0] ColsA = AW'(COLUMNS);

  logic [RW:0]   row_sum;
  logic [RW-1:0] phys_row;
  logic [AW-1:0] addr_d, addr_q;

  assign row_sum  = {1'b0, row_i} + {1'b0, top_i};
  assign phys_row = (row_sum >= (RW+1)'(ROWS)) ? RW'(row_sum - (RW+1)'(ROWS))
                                                : row_sum[RW-1:0];

  always_comb begin
    unique case (op_i)
      AU_LOAD: addr_d = AW'(phys_row) * ColsA + AW'(col_i);
      AU_INC:  addr_d = addr_q + AW'(1);
      AU_CLR:  addr_d = '0;
      default: addr_d = addr_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
    end else begin
      addr_q <= addr_d;
    end
  end

  assign addr_o = addr_q;

endmodule

// ===== rtl/text_terminal_cursor_scroll_top.sv =====
// Text terminal top level: sequencer, cursor, registers and stream ports.
// Depends on ttcs_pkg, ttcs_addr_unit, ttcs_cell_ram and the macros header.
//
// channel | dir | handshake                | payload
// s_axis  | in  | s_axis_tvalid/tready     | tuser op; tdata char, read row, read col
// m_axis  | out | m_axis_tvalid/tready     | tuser scrolled; tdata row, col, cell
// apb     | in  | psel, penable, pwrite    | text_color at byte address 0
//
// Put: with a scroll the bottom row is then blanked one cell a cycle.
// Read: through the registered memory port (states S_RD, S_RDW); out of range or unused op goes straight to the result;
// clear: every cell is written with a blank.
// After reset a pass over all ROWS*COLUMNS cells writes grey spaces; no word taken meanwhile.
// Scroll moves a top-row offset; only the shared address unit touches addresses.
// A finished result waits in the output register; the next word is then accepted.
`include "text_terminal_cursor_scroll_top_macros.svh"

module text_terminal_cursor_scroll_top #(
  parameter int unsigned COLUMNS = ttcs_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = ttcs_pkg::ROWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // char_code[7:0], read_row[12:8], read_col[19:13]
  input  logic [1:0]  s_axis_tuser,  // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // cursor_row[4:0], cursor_col[11:5], cell_value[27:12]
  output logic        m_axis_tuser,  // scrolled[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ttcs_pkg::*;

  localparam int unsigned NCELLS = ROWS * COLUMNS;
  localparam int unsigned AW     = $clog2(NCELLS);
  localparam int unsigned RW     = $clog2(ROWS);
  localparam int unsigned CW     = $clog2(COLUMNS);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_PUT     = 3'd1;
  localparam logic [2:0] S_ROWADDR = 3'd2;
  localparam logic [2:0] S_FILL    = 3'd3;
  localparam logic [2:0] S_CLEAR   = 3'd4;
  localparam logic [2:0] S_RD      = 3'd5;
  localparam logic [2:0] S_RDW     = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [2:0]    state_d, state_q;
  logic          init_d, init_q;
  logic [7:0]    char_d, char_q;
  logic [RW-1:0] row_d, row_q;
  logic [CW-1:0] col_d, col_q;
  logic [RW-1:0] top_d, top_q;
  logic [CW-1:0] cnt_d, cnt_q;
  logic [15:0]   cell_d, cell_q;
  logic          scr_d, scr_q;
  logic [7:0]    color_q;

  logic          out_valid_q;
  logic [4:0]    out_row_q;
  logic [6:0]    out_col_q;
  logic [15:0]   out_cell_q;
  logic          out_scr_q;
  logic          out_load;

  au_op_e        au_op;
  logic [RW-1:0] au_row;
  logic [CW-1:0] au_col;
  logic [AW-1:0] au_addr;

  logic          ram_we;
  logic [15:0]   ram_wdata;
  logic [15:0]   ram_rdata;

  logic          s_fire;
  logic [1:0]    in_op;
  logic [7:0]    in_char;
  logic [4:0]    in_rr;
  logic [6:0]    in_rc;
  logic          rd_ok;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic          cfg_we;
  logic          col_ok;
  logic          top_ok;

  assign in_op   = s_axis_tuser;
  assign in_char = s_axis_tdata[7:0];
  assign in_rr   = s_axis_tdata[12:8];
  assign in_rc   = s_axis_tdata[19:13];

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign rd_ok = ({2'b00, in_rr} < 7'(ROWS)) && ({1'b0, in_rc} < 8'(COLUMNS));

  assign col_inc = {1'b0, col_q} + (CW+1)'(1);
  assign row_inc = {1'b0, row_q} + (RW+1)'(1);

  ttcs_addr_unit #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_addr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (au_op),
    .row_i  (au_row),
    .col_i  (au_col),
    .top_i  (top_q),
    .addr_o (au_addr)
  );

  ttcs_cell_ram #(
    .DEPTH (NCELLS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (au_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    init_d    = init_q;
    char_d    = char_q;
    row_d     = row_q;
    col_d     = col_q;
    top_d     = top_q;
    cnt_d     = cnt_q;
    cell_d    = cell_q;
    scr_d     = scr_q;
    au_op     = AU_HOLD;
    au_row    = row_q;
    au_col    = col_q;
    ram_we    = 1'b0;
    ram_wdata = make_cell(BLANK_CHAR, color_q);
    out_load  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          char_d = in_char;
          cell_d = '0;
          scr_d  = 1'b0;
          unique case (in_op)
            OP_PUT: begin
              au_op   = AU_LOAD;
              state_d = S_PUT;
            end
            OP_CLEAR: begin
              au_op   = AU_CLR;
              row_d   = '0;
              col_d   = '0;
              top_d   = '0;
              state_d = S_CLEAR;
            end
            OP_READ: begin
              au_op   = AU_LOAD;
              au_row  = RW'(in_rr);
              au_col  = CW'(in_rc);
              state_d = rd_ok ? S_RD : S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_PUT: begin
        state_d = S_DONE;
        if (char_q != NEWLINE_CHAR) begin
          ram_we    = 1'b1;
          ram_wdata = make_cell(char_q, color_q);
          cell_d    = make_cell(char_q, color_q);
        end
        if (char_q == NEWLINE_CHAR || col_inc == (CW+1)'(COLUMNS)) begin
          col_d = '0;
          if (row_inc == (RW+1)'(ROWS)) begin
            row_d   = RW'(ROWS - 1);
            top_d   = (top_q == RW'(ROWS - 1)) ? '0 : top_q + RW'(1);
            scr_d   = 1'b1;
            state_d = S_ROWADDR;
          end else begin
            row_d = row_inc[RW-1:0];
          end
        end else begin
          col_d = col_inc[CW-1:0];
        end
      end
      S_ROWADDR: begin
        au_op   = AU_LOAD;
        au_row  = RW'(ROWS - 1);
        au_col  = '0;
        cnt_d   = '0;
        state_d = S_FILL;
      end
      S_FILL: begin
        ram_we = 1'b1;
        au_op  = AU_INC;
        cnt_d  = cnt_q + CW'(1);
        if (cnt_q == CW'(COLUMNS - 1)) begin
          state_d = S_DONE;
        end
      end
      S_CLEAR: begin
        ram_we = 1'b1;
        au_op  = AU_INC;
        if (init_q) begin
          ram_wdata = make_cell(BLANK_CHAR, COLOR_RESET);
        end
        if (au_addr == AW'(NCELLS - 1)) begin
          init_d  = 1'b0;
          state_d = init_q ? S_IDLE : S_DONE;
        end
      end
      S_RD: begin
        state_d = S_RDW;
      end
      S_RDW: begin
        cell_d  = ram_rdata;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      init_q  <= 1'b1;
      row_q   <= '0;
      col_q   <= '0;
      top_q   <= '0;
      cnt_q   <= '0;
      scr_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      row_q   <= row_d;
      col_q   <= col_d;
      top_q   <= top_d;
      cnt_q   <= cnt_d;
      scr_q   <= scr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    cell_q <= cell_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_row_q  <= 5'(row_q);
      out_col_q  <= 7'(col_q);
      out_cell_q <= cell_q;
      out_scr_q  <= scr_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_cell_q, out_col_q, out_row_q};
  assign m_axis_tuser  = out_scr_q;

  // config
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'h0 : {24'h0, color_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= COLOR_RESET;
    end else if (cfg_we) begin
      color_q <= pwdata[7:0];
    end
  end

  assign col_ok = ({1'b0, col_q} < (CW+1)'(COLUMNS));
  assign top_ok = ({1'b0, top_q} < (RW+1)'(ROWS));

  `TTCS_ASSERT(a_col_range, 1'b1, col_ok, "cursor column past last column")
  `TTCS_ASSERT(a_top_range, 1'b1, top_ok, "top row offset out of range")
  `TTCS_ASSERT_NEXT(a_clear_home, s_fire && in_op == OP_CLEAR, au_addr == '0 && row_q == '0 && col_q == '0, "clear did not home cursor and address")
  `TTCS_ASSERT(a_fill_scrolled, state_q == S_FILL, scr_q, "row fill without scroll")

endmodule
